// File: rtl/mpfb_pkg.sv
`timescale 1ns / 1ps

package mpfb_pkg;

    typedef enum logic [1:0] {
        OP_WINDOW = 2'd0,
        OP_BITMAP = 2'd1,
        OP_FILL   = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BMP_LO,
        S_BMP_HI,
        S_FILL,
        S_READ,
        S_RESP
    } t_state;

    localparam logic [15:0] COLOR_ON_MIN = 16'h00FF;
    localparam int unsigned PAGE_ROWS    = 8;

    typedef struct packed {
        logic load;
        logic step;
    } t_win_ctrl;

    typedef struct packed {
        logic       active;
        logic       last;
        logic [8:0] cursor_x;
        logic [8:0] band_top;
        logic [3:0] rows;
    } t_win_status;

endpackage

// File: rtl/mono_page_framebuffer_blitter.sv
`timescale 1ns / 1ps

// Monochrome page frame store (8-row pages, one byte per column, bit 0 on top)
// with a bitmap-window blitter, rectangle fill and byte readback. Every request
// returns exactly one response. After reset the store is swept to zero, one
// byte per cycle, over all ceil(DISPLAY_HEIGHT/8) * DISPLAY_WIDTH bytes with
// o_ready low. Requests are handled one at a time over the single-port-read,
// single-port-write store, writes as read-modify-write passes: window start
// loads the window, read byte reads one store byte, bitmap byte updates its
// upper then lower page byte (first step only with no window open), and fill
// rectangle updates each store byte it touches on the display. A new request
// is taken while the previous response still waits in the output register.
module mono_page_framebuffer_blitter #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_x_first,
    input  logic [7:0]  i_y_first,
    input  logic [7:0]  i_x_last,
    input  logic [7:0]  i_y_last,
    input  logic [7:0]  i_bitmap_byte,
    input  logic [15:0] i_color,
    input  logic [2:0]  i_read_page,
    input  logic [6:0]  i_read_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_window_done
);

    import mpfb_pkg::*;

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int FULL_PAGES  = DISPLAY_HEIGHT / 8;
    localparam logic [7:0] PART_MASK = 8'((1 << (DISPLAY_HEIGHT % 8)) - 1);
    localparam logic [7:0] COL_MAX   = 8'(DISPLAY_WIDTH - 1);
    localparam logic [7:0] ROW_MAX   = 8'(DISPLAY_HEIGHT - 1);

    function automatic logic [7:0] page_mask(input logic [6:0] page);
        logic [7:0] m;
        if (32'(page) < FULL_PAGES) begin
            m = 8'hFF;
        end else if (32'(page) == FULL_PAGES) begin
            m = PART_MASK;
        end else begin
            m = 8'h00;
        end
        return m;
    endfunction

    function automatic logic [AW-1:0] byte_addr(input logic [6:0] page,
                                                 input logic [8:0] col);
        logic [16:0] full;
        full = 17'(page) * 17'(DISPLAY_WIDTH) + 17'(col);
        return full[AW-1:0];
    endfunction

    t_state      r_state, n_state;
    t_opcode     r_op;
    logic [7:0]  r_bits;
    logic        r_on;
    logic        r_fill_ok;
    logic [7:0]  r_col, r_col_first, r_col_last;
    logic [4:0]  r_page, r_page_first, r_page_last;
    logic [2:0]  r_row_first, r_row_last;
    logic        r_rd_ok;
    logic [AW-1:0] r_rd_addr;
    logic        r_done;
    logic        r_wr_en;
    logic [AW-1:0] r_wr_addr;
    logic [7:0]  r_wr_mask, r_wr_val;
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_done;

    logic        clearing;
    logic        accept;
    logic [7:0]  rd_data;
    t_win_ctrl   win_ctrl;
    t_win_status win;

    logic        iss_en, iss_wr;
    logic [AW-1:0] iss_addr;
    logic [7:0]  iss_mask, iss_val;
    logic        out_load;

    logic [2:0]  bmp_off;
    logic [6:0]  bmp_p0, bmp_p1;
    logic [7:0]  row_mask;
    logic [15:0] wide_mask, wide_val;
    logic        col_ok;
    logic [7:0]  mask_lo, mask_hi;
    logic [2:0]  fill_lo, fill_hi;
    logic [7:0]  fill_mask;
    logic [7:0]  x_end, y_end;

    assign o_ready = (r_state == S_IDLE) && !clearing;
    assign accept  = i_valid && o_ready;

    mpfb_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (win_ctrl),
        .i_x_first (i_x_first),
        .i_y_first (i_y_first),
        .i_x_last  (i_x_last),
        .i_y_last  (i_y_last),
        .o_status  (win)
    );

    mpfb_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (iss_en),
        .i_rd_addr  (iss_addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (r_wr_en),
        .i_wr_addr  (r_wr_addr),
        .i_wr_data  ((rd_data & ~r_wr_mask) | (r_wr_val & r_wr_mask)),
        .o_clearing (clearing)
    );

    // bitmap byte spans up to two pages when the band is not page aligned
    always_comb begin
        bmp_off   = win.band_top[2:0];
        bmp_p0    = {1'b0, win.band_top[8:3]};
        bmp_p1    = bmp_p0 + 7'd1;
        row_mask  = 8'((9'd1 << win.rows) - 9'd1);
        wide_mask = {8'h00, row_mask} << bmp_off;
        wide_val  = {8'h00, r_bits} << bmp_off;
        col_ok    = (win.cursor_x < 9'(DISPLAY_WIDTH));
        mask_lo   = col_ok ? (wide_mask[7:0] & page_mask(bmp_p0)) : 8'h00;
        mask_hi   = col_ok ? (wide_mask[15:8] & page_mask(bmp_p1)) : 8'h00;
    end

    always_comb begin
        fill_lo   = (r_page == r_page_first) ? r_row_first : 3'd0;
        fill_hi   = (r_page == r_page_last) ? r_row_last : 3'd7;
        fill_mask = (8'hFF << fill_lo) & (8'hFF >> (3'd7 - fill_hi));
        x_end     = (i_x_last > COL_MAX) ? COL_MAX : i_x_last;
        y_end     = (i_y_last > ROW_MAX) ? ROW_MAX : i_y_last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_WINDOW: n_state = S_RESP;
                        OP_BITMAP: n_state = S_BMP_LO;
                        OP_FILL:   n_state = S_FILL;
                        OP_READ:   n_state = S_READ;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_BMP_LO: n_state = win.active ? S_BMP_HI : S_RESP;
            S_BMP_HI: n_state = S_RESP;
            S_FILL: begin
                if (!r_fill_ok || ((r_col == r_col_last) && (r_page == r_page_last))) begin
                    n_state = S_RESP;
                end
            end
            S_READ: n_state = S_RESP;
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        iss_en        = 1'b0;
        iss_wr        = 1'b0;
        iss_addr      = '0;
        iss_mask      = 8'h00;
        iss_val       = 8'h00;
        win_ctrl.load = 1'b0;
        win_ctrl.step = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                win_ctrl.load = accept && (i_opcode == OP_WINDOW);
            end
            S_BMP_LO: begin
                if (win.active && (mask_lo != 8'h00)) begin
                    iss_en   = 1'b1;
                    iss_wr   = 1'b1;
                    iss_addr = byte_addr(bmp_p0, win.cursor_x);
                    iss_mask = mask_lo;
                    iss_val  = wide_val[7:0];
                end
            end
            S_BMP_HI: begin
                win_ctrl.step = 1'b1;
                if (mask_hi != 8'h00) begin
                    iss_en   = 1'b1;
                    iss_wr   = 1'b1;
                    iss_addr = byte_addr(bmp_p1, win.cursor_x);
                    iss_mask = mask_hi;
                    iss_val  = wide_val[15:8];
                end
            end
            S_FILL: begin
                if (r_fill_ok) begin
                    iss_en   = 1'b1;
                    iss_wr   = 1'b1;
                    iss_addr = byte_addr({2'b00, r_page}, {1'b0, r_col});
                    iss_mask = fill_mask;
                    iss_val  = r_on ? 8'hFF : 8'h00;
                end
            end
            S_READ: begin
                iss_en   = r_rd_ok;
                iss_addr = r_rd_addr;
            end
            S_RESP: begin
                out_load = !r_out_valid || i_ready;
            end
            default: begin
                iss_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_en     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr_en <= iss_en && iss_wr;
            if (accept) begin
                r_done <= 1'b0;
            end else if (win_ctrl.step && win.last) begin
                r_done <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= t_opcode'(i_opcode);
            r_bits       <= i_bitmap_byte;
            r_on         <= (i_color >= COLOR_ON_MIN);
            r_fill_ok    <= (i_x_last >= i_x_first) && (i_y_last >= i_y_first)
                            && ({1'b0, i_x_first} < 9'(DISPLAY_WIDTH))
                            && ({1'b0, i_y_first} < 9'(DISPLAY_HEIGHT));
            r_col        <= i_x_first;
            r_col_first  <= i_x_first;
            r_col_last   <= x_end;
            r_page       <= i_y_first[7:3];
            r_page_first <= i_y_first[7:3];
            r_page_last  <= y_end[7:3];
            r_row_first  <= i_y_first[2:0];
            r_row_last   <= y_end[2:0];
            r_rd_ok      <= (32'(i_read_page) < PAGE_COUNT)
                            && (32'(i_read_column) < DISPLAY_WIDTH);
            r_rd_addr    <= byte_addr({4'b0000, i_read_page}, {2'b00, i_read_column});
        end else if ((r_state == S_FILL) && r_fill_ok) begin
            if (r_col == r_col_last) begin
                r_col  <= r_col_first;
                r_page <= r_page + 5'd1;
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= iss_addr;
        r_wr_mask <= iss_mask;
        r_wr_val  <= iss_val;
        if (out_load) begin
            r_out_data <= ((r_op == OP_READ) && r_rd_ok) ? rd_data : 8'h00;
            r_out_done <= r_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_window_done = r_out_done;

endmodule

// File: rtl/mpfb_store.sv
`timescale 1ns / 1ps

module mpfb_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    output logic          o_clearing
);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // zero sweep after reset, one byte per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// File: rtl/mpfb_window.sv
`timescale 1ns / 1ps

module mpfb_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mpfb_pkg::t_win_ctrl   i_ctrl,
    input  logic [7:0]            i_x_first,
    input  logic [7:0]            i_y_first,
    input  logic [7:0]            i_x_last,
    input  logic [7:0]            i_y_last,
    output mpfb_pkg::t_win_status o_status
);

    import mpfb_pkg::*;

    logic [7:0]  r_origin_x;
    logic [8:0]  r_width;
    logic [8:0]  r_cursor_x;
    logic [8:0]  r_band_top;
    logic [3:0]  r_last_rows;
    logic [15:0] r_bytes_left;

    logic        empty;
    logic [8:0]  height;
    logic [8:0]  width;
    logic [5:0]  pages;
    logic [3:0]  rows_load;
    logic [15:0] bytes_load;
    logic [8:0]  cursor_inc;
    logic        wrap;

    always_comb begin
        empty      = (i_x_last < i_x_first) || (i_y_last < i_y_first);
        height     = {1'b0, i_y_last} - {1'b0, i_y_first} + 9'd1;
        width      = {1'b0, i_x_last} - {1'b0, i_x_first} + 9'd1;
        rows_load  = (height[2:0] == 3'd0) ? 4'(PAGE_ROWS) : {1'b0, height[2:0]};
        pages      = 6'(({1'b0, height} + 10'd7) >> 3);
        bytes_load = 16'(pages) * 16'(width);
        cursor_inc = r_cursor_x + 9'd1;
        wrap       = ((cursor_inc - {1'b0, r_origin_x}) == r_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_width      <= '0;
            r_cursor_x   <= '0;
            r_band_top   <= '0;
            r_last_rows  <= 4'(PAGE_ROWS);
            r_bytes_left <= '0;
        end else if (i_ctrl.load) begin
            r_origin_x <= i_x_first;
            r_cursor_x <= {1'b0, i_x_first};
            r_band_top <= {1'b0, i_y_first};
            if (empty) begin
                r_width      <= '0;
                r_last_rows  <= 4'(PAGE_ROWS);
                r_bytes_left <= '0;
            end else begin
                r_width      <= width;
                r_last_rows  <= rows_load;
                r_bytes_left <= bytes_load;
            end
        end else if (i_ctrl.step) begin
            if (wrap) begin
                r_cursor_x <= {1'b0, r_origin_x};
                r_band_top <= r_band_top + 9'(PAGE_ROWS);
            end else begin
                r_cursor_x <= cursor_inc;
            end
            r_bytes_left <= r_bytes_left - 16'd1;
        end
    end

    always_comb begin
        o_status.active   = (r_bytes_left != 16'd0) && (r_width != 9'd0);
        o_status.last     = (r_bytes_left == 16'd1);
        o_status.cursor_x = r_cursor_x;
        o_status.band_top = r_band_top;
        // last band of the window is trimmed to its height
        o_status.rows     = ({7'b0, r_width} >= r_bytes_left) ? r_last_rows
                                                               : 4'(PAGE_ROWS);
    end

endmodule

// File: rtl/mpfb_checker.sv
`timescale 1ns / 1ps

module mpfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_read_data,
    input logic        o_window_done
);

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("response dropped before taken");

    a_resp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_read_data) && $stable(o_window_done))
        else $error("response changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request taken during store clear");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while busy");

    a_done_xor_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_window_done && (o_read_data != 8'h00)))
        else $error("window done with read data");

endmodule

bind mono_page_framebuffer_blitter mpfb_checker u_mpfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_read_data   (o_read_data),
    .o_window_done (o_window_done)
);

// File: sim/mono_page_framebuffer_blitter_tb.sv
`timescale 1ns / 1ps

module mono_page_framebuffer_blitter_tb;

    import mpfb_pkg::*;

    localparam int          CLK_HALF    = 5;
    localparam int          DISP_W      = 128;
    localparam int          DISP_H      = 64;
    localparam int          PAGES       = (DISP_H + 7) / 8;
    localparam int          STORE_BYTES = DISP_W * PAGES;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          PRINT_MAX   = 40;

    typedef struct {
        t_opcode     op;
        logic [7:0]  x_first;
        logic [7:0]  y_first;
        logic [7:0]  x_last;
        logic [7:0]  y_last;
        logic [7:0]  bitmap_byte;
        logic [15:0] color;
        logic [2:0]  read_page;
        logic [6:0]  read_column;
    } t_blit_req;

    typedef struct {
        logic [7:0] read_data;
        logic       window_done;
    } t_blit_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_x_first = '0;
    logic [7:0]  i_y_first = '0;
    logic [7:0]  i_x_last = '0;
    logic [7:0]  i_y_last = '0;
    logic [7:0]  i_bitmap_byte = '0;
    logic [15:0] i_color = '0;
    logic [2:0]  i_read_page = '0;
    logic [6:0]  i_read_column = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_window_done;

    mono_page_framebuffer_blitter #(
        .DISPLAY_WIDTH (DISP_W),
        .DISPLAY_HEIGHT(DISP_H)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_x_first    (i_x_first),
        .i_y_first    (i_y_first),
        .i_x_last     (i_x_last),
        .i_y_last     (i_y_last),
        .i_bitmap_byte(i_bitmap_byte),
        .i_color      (i_color),
        .i_read_page  (i_read_page),
        .i_read_column(i_read_column),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_data  (o_read_data),
        .o_window_done(o_window_done)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // shadow of the frame store and blitter window
    logic [7:0]  shadow_store [STORE_BYTES];
    logic [7:0]  win_origin_x;
    logic [8:0]  win_width;
    logic [8:0]  win_cursor_x;
    logic [8:0]  win_band_top;
    logic [3:0]  win_last_rows;
    logic [15:0] win_bytes_left;

    t_blit_resp  pending_resp [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          bursty = 1'b1;
    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;

    function automatic void clear_shadow();
        for (int i = 0; i < STORE_BYTES; i++) begin
            shadow_store[i] = 8'h00;
        end
        win_origin_x   = '0;
        win_width      = '0;
        win_cursor_x   = '0;
        win_band_top   = '0;
        win_last_rows  = 4'd8;
        win_bytes_left = '0;
    endfunction

    function automatic void set_pixel(input int x, input int y, input logic on);
        int idx;
        if (x >= DISP_W || y >= DISP_H) begin
            return;
        end
        idx = (y / 8) * DISP_W + x;
        shadow_store[idx][y % 8] = on;
    endfunction

    function automatic t_blit_resp predict_blit(input t_blit_req rq);
        t_blit_resp  resp;
        int unsigned h;
        int unsigned rows;
        logic [8:0]  span;
        logic        on;
        resp.read_data   = 8'h00;
        resp.window_done = 1'b0;
        case (rq.op)
            OP_WINDOW: begin
                win_origin_x = rq.x_first;
                win_cursor_x = {1'b0, rq.x_first};
                win_band_top = {1'b0, rq.y_first};
                if (rq.x_last < rq.x_first || rq.y_last < rq.y_first) begin
                    win_width      = '0;
                    win_last_rows  = 4'd8;
                    win_bytes_left = '0;
                end else begin
                    h              = rq.y_last - rq.y_first + 1;
                    win_width      = 9'(rq.x_last - rq.x_first + 1);
                    win_last_rows  = ((h % 8) == 0) ? 4'd8 : 4'(h % 8);
                    win_bytes_left = 16'(((h + 7) / 8) * win_width);
                end
            end
            OP_BITMAP: begin
                if (win_bytes_left != 0 && win_width != 0) begin
                    rows = (win_bytes_left <= win_width) ? win_last_rows : PAGE_ROWS;
                    for (int m = 0; m < rows; m++) begin
                        set_pixel(int'(win_cursor_x), int'(win_band_top) + m,
                                  rq.bitmap_byte[m]);
                    end
                    win_cursor_x = win_cursor_x + 9'd1;
                    span         = win_cursor_x - {1'b0, win_origin_x};
                    if (span == win_width) begin
                        win_cursor_x = {1'b0, win_origin_x};
                        win_band_top = win_band_top + 9'd8;
                    end
                    win_bytes_left   = win_bytes_left - 16'd1;
                    resp.window_done = (win_bytes_left == 0);
                end
            end
            OP_FILL: begin
                if (rq.x_last >= rq.x_first && rq.y_last >= rq.y_first) begin
                    on = (rq.color >= COLOR_ON_MIN);
                    for (int y = rq.y_first; y <= rq.y_last; y++) begin
                        for (int x = rq.x_first; x <= rq.x_last; x++) begin
                            set_pixel(x, y, on);
                        end
                    end
                end
            end
            default: begin
                if (rq.read_page < PAGES && rq.read_column < DISP_W) begin
                    resp.read_data = shadow_store[rq.read_page * DISP_W + rq.read_column];
                end
            end
        endcase
        return resp;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (mismatch_count < PRINT_MAX) begin
            $display("mismatch %s: expected 0x%0h got 0x%0h at cycle %0d",
                     what, want, got, cycle_count);
        end
        mismatch_count++;
    endtask

    task automatic send_request(input t_blit_req rq);
        i_valid       <= 1'b1;
        i_opcode      <= rq.op;
        i_x_first     <= rq.x_first;
        i_y_first     <= rq.y_first;
        i_x_last      <= rq.x_last;
        i_y_last      <= rq.y_last;
        i_bitmap_byte <= rq.bitmap_byte;
        i_color       <= rq.color;
        i_read_page   <= rq.read_page;
        i_read_column <= rq.read_column;
        do @(posedge i_clk); while (!o_ready);
        pending_resp.push_back(predict_blit(rq));
        if (bursty) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_all_responses();
        i_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_blit_req make_req(input t_opcode op);
        t_blit_req rq;
        rq.op          = op;
        rq.x_first     = 8'($urandom);
        rq.y_first     = 8'($urandom);
        rq.x_last      = 8'($urandom);
        rq.y_last      = 8'($urandom);
        rq.bitmap_byte = 8'($urandom);
        rq.color       = 16'($urandom);
        rq.read_page   = 3'($urandom);
        rq.read_column = 7'($urandom);
        return rq;
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 4))
            0: return 16'h00FE;
            1: return 16'h00FF;
            2: return 16'h0100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_bits();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic do_window(input logic [7:0] x0, input logic [7:0] y0,
                             input logic [7:0] x1, input logic [7:0] y1);
        t_blit_req rq;
        rq         = make_req(OP_WINDOW);
        rq.x_first = x0;
        rq.y_first = y0;
        rq.x_last  = x1;
        rq.y_last  = y1;
        send_request(rq);
    endtask

    task automatic do_bitmap(input logic [7:0] bits);
        t_blit_req rq;
        rq             = make_req(OP_BITMAP);
        rq.bitmap_byte = bits;
        send_request(rq);
    endtask

    task automatic do_fill(input logic [7:0] x0, input logic [7:0] y0, input logic [7:0] x1,
                           input logic [7:0] y1, input logic [15:0] color);
        t_blit_req rq;
        rq         = make_req(OP_FILL);
        rq.x_first = x0;
        rq.y_first = y0;
        rq.x_last  = x1;
        rq.y_last  = y1;
        rq.color   = color;
        send_request(rq);
    endtask

    task automatic do_read(input logic [2:0] page, input logic [6:0] col);
        t_blit_req rq;
        rq             = make_req(OP_READ);
        rq.read_page   = page;
        rq.read_column = col;
        send_request(rq);
    endtask

    task automatic test_reset_clear();
        bursty = 1'b0;
        do_read(3'd0, 7'd0);
        do_read(3'd7, 7'd127);
        wait_all_responses();
    endtask

    task automatic test_fill_rect();
        bursty = 1'b1;
        do_fill(8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF);
        do_read(3'd7, 7'd127);
        do_fill(8'd8, 8'd5, 8'd20, 8'd30, 16'h00FE);
        do_read(3'd0, 7'd10);
        do_fill(8'd30, 8'd40, 8'd20, 8'd50, 16'hFFFF);
        do_fill(8'd0, 8'd0, 8'd255, 8'd255, 16'h0000);
        do_fill(8'd60, 8'd60, 8'd63, 8'd63, 16'h00FF);
        do_read(3'd7, 7'd61);
        wait_all_responses();
    endtask

    task automatic test_bitmap_window();
        bursty = 1'b0;
        // 3 columns, 11 rows: second band keeps only 3 rows
        do_window(8'd3, 8'd2, 8'd5, 8'd12);
        do_bitmap(8'hFF);
        do_bitmap(8'h00);
        do_bitmap(8'hA5);
        do_bitmap(8'h5A);
        do_bitmap(8'hFF);
        do_bitmap(8'h81);
        do_bitmap(8'hFF);
        do_read(3'd1, 7'd5);
        // straddles right and bottom edges
        do_window(8'd126, 8'd60, 8'd129, 8'd67);
        repeat (4) do_bitmap(8'hFF);
        do_read(3'd7, 7'd127);
        do_window(8'd10, 8'd10, 8'd5, 8'd20);
        do_bitmap(8'hFF);
        do_read(3'd1, 7'd10);
        wait_all_responses();
    endtask

    task automatic test_random_windows(input int unsigned target);
        int unsigned n_items;
        int unsigned w;
        int unsigned h;
        int unsigned nbytes;
        int unsigned cut;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [7:0]  x1;
        logic [7:0]  y1;
        n_items = 0;
        while (n_items < target) begin
            bursty = ($urandom_range(0, 3) != 0);
            x0 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(100, 255))
                                              : 8'($urandom_range(0, 127));
            y0 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(50, 255))
                                              : 8'($urandom_range(0, 63));
            w  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            h  = $urandom_range(1, 24);
            x1 = (x0 + w - 1 > 255) ? 8'd255 : 8'(x0 + w - 1);
            y1 = (y0 + h - 1 > 255) ? 8'd255 : 8'(y0 + h - 1);
            w  = x1 - x0 + 1;
            h  = y1 - y0 + 1;
            nbytes = ((h + 7) / 8) * w;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
            do_window(x0, y0, x1, y1);
            for (int k = 0; k < cut; k++) begin
                do_bitmap(pick_bits());
            end
            if ($urandom_range(0, 7) == 0) begin
                do_bitmap(pick_bits());
            end
            if ($urandom_range(0, 9) == 0) begin
                do_fill(x0, y0, 8'(x0 + $urandom_range(0, 7)), 8'(y0 + $urandom_range(0, 9)),
                        pick_color());
                n_items++;
            end
            for (int k = $urandom_range(1, 4); k > 0; k--) begin
                do_read(3'((y0 >> 3) + $urandom_range(0, 2)), 7'(x0 + $urandom_range(0, w - 1)));
            end
            n_items += 1 + cut + 2;
            if ($urandom_range(0, 24) == 0) begin
                wait_all_responses();
            end
        end
        wait_all_responses();
    endtask

    task automatic test_random_mix(input int unsigned target);
        t_blit_req rq;
        for (int unsigned n = 0; n < target; n++) begin
            if (n % 100 == 0) begin
                bursty = ($urandom_range(0, 2) != 0);
            end
            rq = make_req(t_opcode'($urandom_range(0, 3)));
            if (rq.op == OP_FILL) begin
                rq.color = pick_color();
                if ($urandom_range(0, 59) != 0) begin
                    rq.x_last = 8'(rq.x_first + $urandom_range(0, 12)) - 8'($urandom_range(0, 1));
                    rq.y_last = 8'(rq.y_first + $urandom_range(0, 12)) - 8'($urandom_range(0, 1));
                end
            end else if (rq.op == OP_WINDOW && $urandom_range(0, 1) == 0) begin
                rq.x_last = 8'(rq.x_first + $urandom_range(0, 10));
                rq.y_last = 8'(rq.y_first + $urandom_range(0, 20));
            end
            send_request(rq);
        end
        wait_all_responses();
    endtask

    always @(posedge i_clk) begin : resp_check
        t_blit_resp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("response with none pending", 0, 1);
            end else begin
                want = pending_resp.pop_front();
                if (o_read_data !== want.read_data) begin
                    report_mismatch("read_data", want.read_data, o_read_data);
                end
                if (o_window_done !== want.window_done) begin
                    report_mismatch("window_done", want.window_done, o_window_done);
                end
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 0);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= ((stall_left % 16) < 10);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        clear_shadow();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_clear();
        test_fill_rect();
        test_bitmap_window();
        test_random_windows(1150);
        test_random_mix(550);
        wait_all_responses();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/mpfb_pkg.sv
rtl/mpfb_store.sv
rtl/mpfb_window.sv
rtl/mono_page_framebuffer_blitter.sv
rtl/mpfb_checker.sv
sim/mono_page_framebuffer_blitter_tb.sv
